// File: hw/rtl/nvsm_pkg.sv
// Package for the VTG speed monitor: character codes, header text, limits,
// register indexes, reset values and the enum types of parser, link and voice.
// Depends on nothing.
`default_nettype none

package nvsm_pkg;

	// Characters of the sentence framing
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_COMMA  = 8'h2c;
	localparam logic [7:0] CHAR_DOT    = 8'h2e;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;

	// Header "GPVTG", index 0 is the first character after '$'
	localparam int unsigned HDR_LEN = 5;
	localparam logic [HDR_LEN-1:0][7:0] HDR_TEXT = {8'h47, 8'h54, 8'h56, 8'h50, 8'h47};

	localparam logic [7:0] SPEED_NO_SIGNAL = 8'hff;
	localparam logic [7:0] SILENCE_HOLD    = 8'd10;
	localparam logic [3:0] DIGITS_MAX      = 4'd3;
	localparam logic [3:0] COUNT_SAT       = 4'd15;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_NO_SIGNAL_LIMIT = 2'd0;
	localparam logic [1:0] REG_CHECK_PERIOD    = 2'd1;
	localparam logic [1:0] REG_BLINK_LIMIT     = 2'd2;
	localparam logic [1:0] REG_SPEED_COMMAS    = 2'd3;

	// Register reset values
	localparam logic [7:0] RST_NO_SIGNAL_LIMIT = 8'd160;
	localparam logic [7:0] RST_CHECK_PERIOD    = 8'd160;
	localparam logic [6:0] RST_BLINK_LIMIT     = 7'd100;
	localparam logic [3:0] RST_SPEED_COMMAS    = 4'd7;

	typedef enum logic [1:0] {
		PH_HUNT   = 2'd0,
		PH_HEADER = 2'd1,
		PH_SKIP   = 2'd2,
		PH_DIGITS = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		LINK_UNKNOWN = 2'd0,
		LINK_UP      = 2'd1,
		LINK_DOWN    = 2'd2
	} link_t;

	typedef enum logic [1:0] {
		VOICE_NONE = 2'd0,
		VOICE_UP   = 2'd1,
		VOICE_DOWN = 2'd2
	} voice_t;

endpackage

`default_nettype wire

// File: hw/rtl/nmea_vtg_speed_monitor.sv
// Top level of the VTG speed monitor: input register, sentence parser,
// tick logic for speed, link and LED, and the result register.
// Depends on nvsm_pkg.
`default_nettype none

// Speed and link monitor for an NMEA 0183 VTG character stream. Each input
// beat is either one received character (s_tuser low) or one 10 ms tick
// (s_tuser high), and each gives exactly one result beat with the shown
// speed in km/h (255 after a no-signal timeout), the link state, a voice
// event code (only ever nonzero on a tick) and the power LED level.
// A beat is taken into an input register, processed in a single pass of
// short logic against the parser and tick state, and lands in the result
// register; one beat is accepted every cycle while the sink takes results.
// The result register drains while the next beat is taken, so throughput
// stays at one beat per cycle as long as the sink takes results; a stalled
// sink backs up through the input register one beat deep. Configuration
// writes take effect at once and belong in idle time only.
module nmea_vtg_speed_monitor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [7:0] rx_byte, [8] pwr_on, [15:9] zero
	input  wire logic        s_tuser,  // [0] func: 0 character, 1 tick
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,  // [7:0] speed_kmh, [9:8] link_state,
	                                   // [11:10] voice_event, [12] led_level, [15:13] zero
	// Configuration
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [7:0]  cfg_wdata
);

	// Configuration registers
	logic [7:0] no_signal_limit_q;
	logic [7:0] check_period_q;
	logic [6:0] blink_limit_q;
	logic [3:0] speed_commas_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_signal_limit_q <= nvsm_pkg::RST_NO_SIGNAL_LIMIT;
			check_period_q    <= nvsm_pkg::RST_CHECK_PERIOD;
			blink_limit_q     <= nvsm_pkg::RST_BLINK_LIMIT;
			speed_commas_q    <= nvsm_pkg::RST_SPEED_COMMAS;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				nvsm_pkg::REG_NO_SIGNAL_LIMIT: no_signal_limit_q <= cfg_wdata;
				nvsm_pkg::REG_CHECK_PERIOD:    check_period_q    <= cfg_wdata;
				nvsm_pkg::REG_BLINK_LIMIT:     blink_limit_q     <= cfg_wdata[6:0];
				nvsm_pkg::REG_SPEED_COMMAS:    speed_commas_q    <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// Input register
	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;
	logic       open_s1;
	logic       advance;

	// Process the held beat when the result register is free or draining
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			byte_s1 <= s_tdata[7:0];
			open_s1 <= s_tdata[8];
		end
	end

	// Parser and tick state
	nvsm_pkg::phase_t phase_q, phase_d;
	logic [3:0]       pos_q, pos_d;
	logic [7:0]       char_q [nvsm_pkg::HDR_LEN];
	logic [7:0]       pend_speed_q, pend_speed_d;
	logic             pend_valid_q, pend_valid_d;
	logic             seen_q, seen_d;
	logic [7:0]       shown_q, shown_d;
	logic [7:0]       silence_q, silence_d;
	logic [7:0]       period_q, period_d;
	nvsm_pkg::link_t  link_q, link_d;
	logic [6:0]       blink_q, blink_d;
	logic             led_q, led_d;
	nvsm_pkg::voice_t voice_d;

	logic       is_char;
	logic       is_tick;
	logic       hdr_done;
	logic       hdr_ok;
	logic [3:0] comma_pos;
	logic       is_term;
	logic       char_wr;
	logic [7:0] char_wdata;
	logic [7:0] digit_val;

	assign is_char = advance && !func_s1;
	assign is_tick = advance && func_s1;

	// Fifth header character completes the check against the stored four
	assign hdr_done = (pos_q == 4'(nvsm_pkg::HDR_LEN - 1));
	assign hdr_ok   = (char_q[0] == nvsm_pkg::HDR_TEXT[0]) &&
	                  (char_q[1] == nvsm_pkg::HDR_TEXT[1]) &&
	                  (char_q[2] == nvsm_pkg::HDR_TEXT[2]) &&
	                  (char_q[3] == nvsm_pkg::HDR_TEXT[3]) &&
	                  (byte_s1 == nvsm_pkg::HDR_TEXT[4]);

	assign comma_pos = (byte_s1 == nvsm_pkg::CHAR_COMMA) ? pos_q + 4'd1 : pos_q;
	assign is_term   = (byte_s1 == nvsm_pkg::CHAR_COMMA) || (byte_s1 == nvsm_pkg::CHAR_DOT);

	// Speed from the stored digits, modulo 256
	always_comb begin
		unique case (pos_q)
			4'd1:    digit_val = char_q[0];
			4'd2:    digit_val = 8'(char_q[0] * 8'd10) + char_q[1];
			default: digit_val = 8'(char_q[0] * 8'd100) + 8'(char_q[1] * 8'd10) + char_q[2];
		endcase
	end

	// Parser next state
	always_comb begin
		phase_d = phase_q;
		if (is_char) begin
			unique case (phase_q)
				nvsm_pkg::PH_HUNT: begin
					if (byte_s1 == nvsm_pkg::CHAR_DOLLAR)
						phase_d = nvsm_pkg::PH_HEADER;
				end
				nvsm_pkg::PH_HEADER: begin
					if (hdr_done)
						phase_d = hdr_ok ? nvsm_pkg::PH_SKIP : nvsm_pkg::PH_HUNT;
				end
				nvsm_pkg::PH_SKIP: begin
					if (comma_pos == speed_commas_q)
						phase_d = nvsm_pkg::PH_DIGITS;
				end
				nvsm_pkg::PH_DIGITS: begin
					if (is_term)
						phase_d = nvsm_pkg::PH_HUNT;
				end
				default: phase_d = nvsm_pkg::PH_HUNT;
			endcase
		end
	end

	// Parser datapath
	always_comb begin
		pos_d        = pos_q;
		char_wr      = 1'b0;
		char_wdata   = byte_s1;
		pend_speed_d = pend_speed_q;
		pend_valid_d = pend_valid_q;
		seen_d       = seen_q;
		if (is_char) begin
			unique case (phase_q)
				nvsm_pkg::PH_HUNT: begin
					if (byte_s1 == nvsm_pkg::CHAR_DOLLAR)
						pos_d = '0;
				end
				nvsm_pkg::PH_HEADER: begin
					char_wr = (pos_q < 4'(nvsm_pkg::HDR_LEN));
					pos_d   = hdr_done ? '0 : pos_q + 4'd1;
				end
				nvsm_pkg::PH_SKIP: begin
					pos_d = (comma_pos == speed_commas_q) ? '0 : comma_pos;
				end
				nvsm_pkg::PH_DIGITS: begin
					if (is_term) begin
						if (pos_q != '0) begin
							seen_d = 1'b1;
							if (pos_q <= nvsm_pkg::DIGITS_MAX) begin
								pend_speed_d = digit_val;
								pend_valid_d = 1'b1;
							end
						end
						pos_d = '0;
					end else begin
						char_wr    = (pos_q < 4'(nvsm_pkg::HDR_LEN));
						char_wdata = byte_s1 - nvsm_pkg::CHAR_ZERO;
						if (pos_q < nvsm_pkg::COUNT_SAT)
							pos_d = pos_q + 4'd1;
					end
				end
				default: ;
			endcase
		end
		// A tick consumes the pending speed and closes a check period
		if (is_tick) begin
			pend_valid_d = 1'b0;
			if ({1'b0, period_q} + 9'd1 > {1'b0, check_period_q})
				seen_d = 1'b0;
		end
	end

	// Tick logic: shown speed, silence timeout, link check, LED blink
	logic [8:0] sil_inc;
	logic [8:0] sil_hold;
	logic [8:0] per_inc;
	logic [7:0] blk_inc;

	assign sil_inc  = (silence_q == 8'hff) ? 9'd255 : {1'b0, silence_q} + 9'd1;
	assign sil_hold = {1'b0, no_signal_limit_q} + {1'b0, nvsm_pkg::SILENCE_HOLD};
	assign per_inc  = {1'b0, period_q} + 9'd1;
	assign blk_inc  = {1'b0, blink_q} + 8'd1;

	always_comb begin
		shown_d   = shown_q;
		silence_d = silence_q;
		period_d  = period_q;
		link_d    = link_q;
		blink_d   = blink_q;
		led_d     = led_q;
		voice_d   = nvsm_pkg::VOICE_NONE;
		if (is_tick) begin
			if (pend_valid_q) begin
				silence_d = '0;
				shown_d   = pend_speed_q;
			end else if (sil_inc > {1'b0, no_signal_limit_q}) begin
				silence_d = (sil_hold > 9'd255) ? 8'hff : sil_hold[7:0];
				shown_d   = nvsm_pkg::SPEED_NO_SIGNAL;
			end else begin
				silence_d = sil_inc[7:0];
			end

			if (per_inc > {1'b0, check_period_q}) begin
				period_d = '0;
				priority case (link_q)
					nvsm_pkg::LINK_UP: begin
						if (!seen_q) begin
							link_d  = nvsm_pkg::LINK_DOWN;
							voice_d = nvsm_pkg::VOICE_DOWN;
						end
					end
					nvsm_pkg::LINK_DOWN: begin
						if (seen_q) begin
							link_d  = nvsm_pkg::LINK_UP;
							voice_d = nvsm_pkg::VOICE_UP;
							led_d   = 1'b1;
						end
					end
					default: begin
						if (seen_q) begin
							link_d  = nvsm_pkg::LINK_UP;
							voice_d = nvsm_pkg::VOICE_UP;
							led_d   = 1'b1;
						end else begin
							link_d  = nvsm_pkg::LINK_DOWN;
							voice_d = nvsm_pkg::VOICE_DOWN;
						end
					end
				endcase
			end else begin
				period_d = per_inc[7:0];
			end

			// Blink on the link state this tick leaves behind
			if (link_d == nvsm_pkg::LINK_DOWN && open_s1) begin
				if (blk_inc > {1'b0, blink_limit_q}) begin
					blink_d = '0;
					led_d   = !led_d;
				end else begin
					blink_d = blk_inc[6:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= nvsm_pkg::PH_HUNT;
			pos_q        <= '0;
			pend_speed_q <= '0;
			pend_valid_q <= 1'b0;
			seen_q       <= 1'b0;
			shown_q      <= '0;
			silence_q    <= '0;
			period_q     <= '0;
			link_q       <= nvsm_pkg::LINK_UNKNOWN;
			blink_q      <= '0;
			led_q        <= 1'b1;
		end else begin
			phase_q      <= phase_d;
			pos_q        <= pos_d;
			pend_speed_q <= pend_speed_d;
			pend_valid_q <= pend_valid_d;
			seen_q       <= seen_d;
			shown_q      <= shown_d;
			silence_q    <= silence_d;
			period_q     <= period_d;
			link_q       <= link_d;
			blink_q      <= blink_d;
			led_q        <= led_d;
		end
	end

	// Character store holds header letters, then digit values
	always_ff @(posedge clk) begin
		if (char_wr)
			char_q[pos_q[2:0]] <= char_wdata;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			m_tdata <= {3'b000, led_d, voice_d, link_d, shown_d};
	end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for the VTG speed monitor: streams characters and ticks through
// the block and checks every result beat against an in-bench speed/link model.
// Depends on nvsm_pkg and nmea_vtg_speed_monitor.

module tb;
	import nvsm_pkg::*;

	localparam int unsigned STALL_LIMIT = 3000;

	typedef struct packed {
		logic       func;
		logic       pwr_on;
		logic [7:0] ch;
	} beat_t;

	typedef struct packed {
		logic       led;
		voice_t     voice;
		link_t      link;
		logic [7:0] speed;
	} report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // [7:0] rx_byte, [8] pwr_on, [15:9] zero
	logic        s_tuser = 1'b0;  // [0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;  // [7:0] speed, [9:8] link, [11:10] voice, [12] led
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [7:0]  cfg_wdata = '0;

	beat_t       rx_beats[$];
	report_t     reports_due[$];
	int unsigned src_gap_pct = 35;
	int unsigned snk_stall_pct = 81;
	int unsigned err_count = 0;
	int unsigned quiet_cycles = 0;

	// Model copy of the registers
	logic [7:0] lim_nosig = RST_NO_SIGNAL_LIMIT;
	logic [7:0] chk_period = RST_CHECK_PERIOD;
	logic [6:0] blink_lim = RST_BLINK_LIMIT;
	logic [3:0] field_commas = RST_SPEED_COMMAS;

	// Model copy of the parser and tick state
	phase_t     prs_phase = PH_HUNT;
	logic [3:0] prs_count = '0;
	logic [7:0] prs_chars [HDR_LEN];
	logic [7:0] pend_speed = '0;
	bit         pend_valid = 1'b0;
	bit         sig_seen = 1'b0;
	logic [7:0] shown = '0;
	logic [7:0] silence = '0;
	logic [7:0] period_cnt = '0;
	link_t      lnk = LINK_UNKNOWN;
	logic [6:0] blink_cnt = '0;
	logic       led_pin = 1'b1;

	nmea_vtg_speed_monitor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Advance the model by one beat and return the result it shows.
	function automatic report_t advance_monitor(beat_t b);
		report_t rep;
		voice_t  voice;
		int      acc;
		int      nxt;
		bit      hdr_ok;
		voice = VOICE_NONE;
		if (!b.func) begin
			case (prs_phase)
			PH_HUNT: begin
				if (b.ch == CHAR_DOLLAR) begin
					prs_phase = PH_HEADER;
					prs_count = '0;
				end
			end
			PH_HEADER: begin
				if (prs_count < HDR_LEN)
					prs_chars[prs_count[2:0]] = b.ch;
				prs_count++;
				if (prs_count >= HDR_LEN) begin
					hdr_ok = 1'b1;
					for (int i = 0; i < HDR_LEN; i++)
						if (prs_chars[i] != HDR_TEXT[i])
							hdr_ok = 1'b0;
					// a bad header drops back to hunting; the failing byte is not rescanned
					if (hdr_ok)
						prs_phase = PH_SKIP;
					else
						prs_phase = PH_HUNT;
					prs_count = '0;
				end
			end
			PH_SKIP: begin
				// comma count wraps at 16, so a zero setting can still be hit
				if (b.ch == CHAR_COMMA)
					prs_count++;
				if (prs_count == field_commas) begin
					prs_count = '0;
					prs_phase = PH_DIGITS;
				end
			end
			default: begin
				if (b.ch == CHAR_COMMA || b.ch == CHAR_DOT) begin
					if (prs_count != 0) begin
						sig_seen = 1'b1;
						if (prs_count <= DIGITS_MAX) begin
							acc = 0;
							for (int i = 0; i < prs_count; i++)
								acc = acc * 10 + prs_chars[i];
							pend_speed = acc[7:0];
							pend_valid = 1'b1;
						end
					end
					prs_count = '0;
					prs_phase = PH_HUNT;
				end else begin
					// non-digits go in as raw offsets from '0'
					if (prs_count < HDR_LEN)
						prs_chars[prs_count[2:0]] = b.ch - CHAR_ZERO;
					if (prs_count < COUNT_SAT)
						prs_count++;
				end
			end
			endcase
		end else begin
			if (pend_valid) begin
				pend_valid = 1'b0;
				silence = '0;
				shown = pend_speed;
			end else begin
				nxt = silence + 1;
				if (nxt > 255)
					nxt = 255;
				if (nxt > lim_nosig) begin
					nxt = lim_nosig + SILENCE_HOLD;
					if (nxt > 255)
						nxt = 255;
					shown = SPEED_NO_SIGNAL;
				end
				silence = nxt[7:0];
			end
			nxt = period_cnt + 1;
			if (nxt > chk_period) begin
				period_cnt = '0;
				case (lnk)
				LINK_UP: begin
					if (!sig_seen) begin
						lnk = LINK_DOWN;
						voice = VOICE_DOWN;
					end
				end
				LINK_DOWN: begin
					if (sig_seen) begin
						lnk = LINK_UP;
						voice = VOICE_UP;
						led_pin = 1'b1;
					end
				end
				default: begin
					if (sig_seen) begin
						lnk = LINK_UP;
						voice = VOICE_UP;
						led_pin = 1'b1;
					end else begin
						lnk = LINK_DOWN;
						voice = VOICE_DOWN;
					end
				end
				endcase
				sig_seen = 1'b0;
			end else begin
				period_cnt = nxt[7:0];
			end
			if (lnk == LINK_DOWN && b.pwr_on) begin
				nxt = blink_cnt + 1;
				if (nxt > blink_lim) begin
					blink_cnt = '0;
					led_pin = ~led_pin;
				end else begin
					blink_cnt = nxt[6:0];
				end
			end
		end
		rep.speed = shown;
		rep.link = lnk;
		rep.voice = voice;
		rep.led = led_pin;
		return rep;
	endfunction

	function automatic void push_char(logic [7:0] c);
		beat_t b;
		b.func = 1'b0;
		b.pwr_on = $urandom_range(0, 1);
		b.ch = c;
		rx_beats.push_back(b);
	endfunction

	function automatic void push_tick(logic pwr_on);
		beat_t b;
		b.func = 1'b1;
		b.pwr_on = pwr_on;
		b.ch = $urandom_range(0, 255);
		rx_beats.push_back(b);
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endfunction

	// Slip a tick in ahead of a character now and then.
	function automatic void put_char(logic [7:0] c, int tick_pct);
		if ($urandom_range(0, 99) < tick_pct)
			push_tick($urandom_range(0, 9) < 7);
		push_char(c);
	endfunction

	function automatic logic [7:0] filler();
		string set;
		set = "0123456789.ANKTMEW";
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	function automatic logic [7:0] odd_char();
		logic [7:0] c;
		do
			c = $urandom_range(0, 255);
		while (c == CHAR_COMMA || c == CHAR_DOT);
		return c;
	endfunction

	// One VTG sentence with random content; now and then a broken header
	// or an empty or overlong speed field.
	function automatic void gen_sentence(int tick_pct);
		logic [7:0] hdr [HDR_LEN];
		int         r;
		int         ndig;
		for (int i = 0; i < HDR_LEN; i++)
			hdr[i] = HDR_TEXT[i];
		if ($urandom_range(0, 9) == 0)
			hdr[$urandom_range(0, HDR_LEN - 1)] = $urandom_range(0, 255);
		put_char(CHAR_DOLLAR, tick_pct);
		for (int i = 0; i < HDR_LEN; i++)
			put_char(hdr[i], tick_pct);
		if (field_commas == 0) begin
			// zero commas: the first non-comma byte opens the field and is eaten
			put_char(filler(), tick_pct);
		end else begin
			for (int k = 1; k <= field_commas; k++) begin
				put_char(CHAR_COMMA, tick_pct);
				if (k < field_commas)
					repeat ($urandom_range(0, 3)) put_char(filler(), tick_pct);
			end
		end
		r = $urandom_range(0, 19);
		ndig = (r < 2) ? 0 : (r < 16) ? $urandom_range(1, 3) : $urandom_range(4, 7);
		repeat (ndig) begin
			if ($urandom_range(0, 9) < 9)
				put_char(CHAR_ZERO + $urandom_range(0, 9), tick_pct);
			else
				put_char(odd_char(), tick_pct);
		end
		put_char(($urandom_range(0, 9) < 7) ? CHAR_COMMA : CHAR_DOT, tick_pct);
		repeat ($urandom_range(0, 4)) put_char(filler(), tick_pct);
	endfunction

	function automatic void gen_random(int n, int tick_pct, int burst_max);
		int base;
		int r;
		base = rx_beats.size();
		while (rx_beats.size() - base < n) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				repeat ($urandom_range(1, 8)) put_char($urandom_range(0, 255), tick_pct);
			end else if (r < 18) begin
				// tick bursts push the silence and period counters along
				repeat ($urandom_range(1, burst_max)) push_tick($urandom_range(0, 9) < 7);
			end else begin
				gen_sentence(tick_pct);
			end
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (err_count < 100)
			$display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
		err_count++;
	endtask

	// Hold until every beat is sent and every result is back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (rx_beats.size() != 0 || s_tvalid || reports_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(logic [7:0] v0, logic [7:0] v1, logic [7:0] v2, logic [7:0] v3);
		lim_nosig = v0;
		chk_period = v1;
		blink_lim = v2[6:0];
		field_commas = v3[3:0];
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= REG_NO_SIGNAL_LIMIT;
		cfg_wdata <= v0;
		@(posedge clk);
		cfg_addr <= REG_CHECK_PERIOD;
		cfg_wdata <= v1;
		@(posedge clk);
		cfg_addr <= REG_BLINK_LIMIT;
		cfg_wdata <= v2;
		@(posedge clk);
		cfg_addr <= REG_SPEED_COMMAS;
		cfg_wdata <= v3;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int gap, int stall, logic [7:0] v0, logic [7:0] v1,
			logic [7:0] v2, logic [7:0] v3, int n, int tick_pct, int burst_max);
		wait_drained();
		src_gap_pct = gap;
		snk_stall_pct = stall;
		set_regs(v0, v1, v2, v3);
		gen_random(n, tick_pct, burst_max);
	endtask

	// Feed beats from the queue; predict each one as it is taken.
	always @(posedge clk or negedge arst_n) begin : feed
		beat_t cur;
		beat_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				cur.func = s_tuser;
				cur.pwr_on = s_tdata[8];
				cur.ch = s_tdata[7:0];
				reports_due.push_back(advance_monitor(cur));
			end
			if (!s_tvalid || s_tready) begin
				if (rx_beats.size() != 0 && $urandom_range(0, 99) >= src_gap_pct) begin
					nxt = rx_beats.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, nxt.pwr_on, nxt.ch};
					s_tuser <= nxt.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Take result beats and compare each field with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : take
		report_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (reports_due.size() == 0) begin
					report_mismatch("result beat with nothing expected", m_tdata, 0);
				end else begin
					want = reports_due.pop_front();
					if (m_tdata[7:0] !== want.speed)
						report_mismatch("speed_kmh", m_tdata[7:0], want.speed);
					if (m_tdata[9:8] !== want.link)
						report_mismatch("link_state", m_tdata[9:8], want.link);
					if (m_tdata[11:10] !== want.voice)
						report_mismatch("voice_event", m_tdata[11:10], want.voice);
					if (m_tdata[12] !== want.led)
						report_mismatch("led_level", m_tdata[12], want.led);
				end
			end
			m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// Drop the run if no beat moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: limits of one, blink limit zero, one comma before the field
		wait_drained();
		set_regs(8'd1, 8'd1, 8'd0, 8'd1);
		push_text("$GPVTG,999.");  // three digits, truncated to 8 bits
		push_tick(1'b1);
		push_char(8'h00);
		push_char(8'hff);
		push_text("$GPVTX");       // bad header
		push_tick(1'b1);           // first link check: connected
		push_tick(1'b0);           // silence timeout
		push_tick(1'b1);           // second link check: lost, LED blinks
		gen_random(150, 20, 20);

		run_phase(35, 81, 8'd250, 8'd255, 8'd127, 8'd15, 180, 25, 60);
		run_phase(81, 35, RST_NO_SIGNAL_LIMIT, RST_CHECK_PERIOD, RST_BLINK_LIMIT,
			RST_SPEED_COMMAS, 250, 25, 60);
		// limit 255 never times out; zero commas takes the first byte as the field
		run_phase(81, 35, 8'd255, 8'd2, 8'd1, 8'd0, 170, 20, 20);
		run_phase(0, 0, 8'd3, 8'd5, 8'd3, 8'd2, 150, 20, 20);
		run_phase(0, 0, 8'd20, 8'd12, 8'd6, 8'd4, 150, 20, 30);

		wait_drained();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/nvsm_pkg.sv
hw/rtl/nmea_vtg_speed_monitor.sv
tb/sv/tb.sv
